// ===== hw/rtl/jkse_pkg.sv =====
// shared types and constants for the json key string extractor
package jkse_pkg;

	localparam int unsigned KEY_MAX = 16;
	localparam int unsigned KLEN_W = 5;
	localparam int unsigned KIDX_W = 4;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 2'd3;

	localparam logic [CNT_W-1:0] OUT_LIMIT_RESET = 16'd64;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_COLON     = 8'h3a;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_N         = 8'h6e;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_R         = 8'h72;

	typedef enum logic [7:0] {
		MODE_SEEK_OPEN  = 8'b0000_0001,
		MODE_COMPARE    = 8'b0000_0010,
		MODE_SKIP_CLOSE = 8'b0000_0100,
		MODE_SEEK_COLON = 8'b0000_1000,
		MODE_SKIP_WS    = 8'b0001_0000,
		MODE_VALUE      = 8'b0010_0000,
		MODE_ESCAPE     = 8'b0100_0000,
		MODE_DONE       = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [KLEN_W-1:0]     key_length;
		logic [2*CFG_DATA_W-1:0] key_bytes;
		logic [CNT_W-1:0]      out_limit;
	} cfg_t;

	typedef struct packed {
		logic       value_valid;
		logic [7:0] value_byte;
		logic       finished;
		logic       outcome;
	} res_t;

endpackage

// ===== hw/rtl/jkse_cfg.sv =====
// configuration register file for the key and output limit
module jkse_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0]     cfg_data,
	output jkse_pkg::cfg_t                      cfg
);

	logic [jkse_pkg::KLEN_W-1:0]     key_length_q;
	logic [jkse_pkg::CFG_DATA_W-1:0] key_low_q;
	logic [jkse_pkg::CFG_DATA_W-1:0] key_high_q;
	logic [jkse_pkg::CNT_W-1:0]      out_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
			key_low_q    <= '0;
			key_high_q   <= '0;
			out_limit_q  <= jkse_pkg::OUT_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				jkse_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data[jkse_pkg::KLEN_W-1:0];
				jkse_pkg::REG_KEY_LOW:    key_low_q    <= cfg_data;
				jkse_pkg::REG_KEY_HIGH:   key_high_q   <= cfg_data;
				jkse_pkg::REG_OUT_LIMIT:  out_limit_q  <= cfg_data[jkse_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.key_length = key_length_q;
	assign cfg.key_bytes  = {key_high_q, key_low_q};
	assign cfg.out_limit  = out_limit_q;

endmodule

// ===== hw/rtl/jkse_scan.sv =====
// scan state machine: key match, value unescape and result for one byte
module jkse_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     text_byte,
	input  logic           is_final,
	input  jkse_pkg::cfg_t cfg,
	output jkse_pkg::res_t res
);

	jkse_pkg::mode_t                 mode_q, mode_d;
	logic [jkse_pkg::KLEN_W-1:0]     match_pos_q, match_pos_d;
	logic [jkse_pkg::CNT_W-1:0]      emitted_q, emitted_d;
	logic                            failed_q, failed_d;

	logic [jkse_pkg::KLEN_W-1:0]     klen;
	logic [jkse_pkg::CNT_W-1:0]      room;
	logic                            lim_zero;
	logic                            at_room;
	logic [7:0]                      key_byte;
	logic                            is_quote;
	logic                            valid;
	logic [7:0]                      vbyte;
	logic                            reached;

	always_comb begin
		if (cfg.key_length > jkse_pkg::KLEN_W'(jkse_pkg::KEY_MAX)) begin
			klen = jkse_pkg::KLEN_W'(jkse_pkg::KEY_MAX);
		end else begin
			klen = cfg.key_length;
		end
	end

	assign lim_zero = (cfg.out_limit == '0);
	assign room     = lim_zero ? '0 : cfg.out_limit - 1'b1;
	assign at_room  = (emitted_q >= room);
	assign key_byte = cfg.key_bytes[match_pos_q[jkse_pkg::KIDX_W-1:0]*8 +: 8];
	assign is_quote = (text_byte == jkse_pkg::CH_QUOTE);

	always_comb begin
		mode_d      = mode_q;
		match_pos_d = match_pos_q;
		emitted_d   = emitted_q;
		failed_d    = failed_q;
		valid       = 1'b0;
		vbyte       = '0;
		case (mode_q)
			jkse_pkg::MODE_SEEK_OPEN: begin
				if (is_quote) begin
					mode_d      = jkse_pkg::MODE_COMPARE;
					match_pos_d = '0;
				end
			end
			jkse_pkg::MODE_COMPARE: begin
				if (match_pos_q < klen) begin
					if (text_byte == key_byte) begin
						match_pos_d = match_pos_q + 1'b1;
					end else begin
						mode_d = is_quote ? jkse_pkg::MODE_SEEK_OPEN : jkse_pkg::MODE_SKIP_CLOSE;
					end
				end else begin
					mode_d = is_quote ? jkse_pkg::MODE_SEEK_COLON : jkse_pkg::MODE_SKIP_CLOSE;
				end
			end
			jkse_pkg::MODE_SKIP_CLOSE: begin
				if (is_quote) begin
					mode_d = jkse_pkg::MODE_SEEK_OPEN;
				end
			end
			jkse_pkg::MODE_SEEK_COLON: begin
				if (text_byte == jkse_pkg::CH_COLON) begin
					mode_d = jkse_pkg::MODE_SKIP_WS;
				end
			end
			jkse_pkg::MODE_SKIP_WS: begin
				if (is_quote) begin
					mode_d    = jkse_pkg::MODE_VALUE;
					emitted_d = '0;
				end else if (!(text_byte inside {jkse_pkg::CH_SPACE, jkse_pkg::CH_TAB,
						jkse_pkg::CH_LF, jkse_pkg::CH_CR})) begin
					mode_d   = jkse_pkg::MODE_DONE;
					failed_d = 1'b1;
				end
			end
			jkse_pkg::MODE_VALUE: begin
				if (at_room || is_quote) begin
					mode_d = jkse_pkg::MODE_DONE;
				end else if (text_byte == jkse_pkg::CH_BACKSLASH && !is_final) begin
					mode_d = jkse_pkg::MODE_ESCAPE;
				end else begin
					valid     = 1'b1;
					vbyte     = text_byte;
					emitted_d = emitted_q + 1'b1;
				end
			end
			jkse_pkg::MODE_ESCAPE: begin
				if (at_room) begin
					mode_d = jkse_pkg::MODE_DONE;
				end else begin
					valid     = 1'b1;
					emitted_d = emitted_q + 1'b1;
					mode_d    = jkse_pkg::MODE_VALUE;
					case (text_byte)
						jkse_pkg::CH_N: vbyte = jkse_pkg::CH_LF;
						jkse_pkg::CH_T: vbyte = jkse_pkg::CH_TAB;
						jkse_pkg::CH_R: vbyte = jkse_pkg::CH_CR;
						default:        vbyte = text_byte;
					endcase
				end
			end
			jkse_pkg::MODE_DONE: ;
			default: ;
		endcase
	end

	// outcome looks at the state after this byte
	assign reached = (mode_d == jkse_pkg::MODE_VALUE || mode_d == jkse_pkg::MODE_ESCAPE ||
		mode_d == jkse_pkg::MODE_DONE) && !failed_d && !lim_zero;

	assign res.value_valid = valid;
	assign res.value_byte  = vbyte;
	assign res.finished    = is_final;
	assign res.outcome     = is_final && !reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= jkse_pkg::MODE_SEEK_OPEN;
			match_pos_q <= '0;
			emitted_q   <= '0;
			failed_q    <= 1'b0;
		end else if (step) begin
			if (is_final) begin
				mode_q      <= jkse_pkg::MODE_SEEK_OPEN;
				match_pos_q <= '0;
				emitted_q   <= '0;
				failed_q    <= 1'b0;
			end else begin
				mode_q      <= mode_d;
				match_pos_q <= match_pos_d;
				emitted_q   <= emitted_d;
				failed_q    <= failed_d;
			end
		end
	end

endmodule

// ===== hw/rtl/json_key_string_extractor.sv =====
// top level of the json key string extractor
//
//  channel | direction | handshake            | payload
//  in      | receive   | in_valid / in_stall  | text_byte, is_final
//  out     | send      | out_valid / out_stall| value_valid, value_byte, finished, outcome
//  cfg     | receive   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a byte's result passes from
// the input register through the scan logic into the result register
// reset clears the scan state and loads the register defaults (out_limit 64)
// a stalled result holds in the result register while one more byte waits in the
// input register; in_stall rises only when both are full
module json_key_string_extractor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            is_final,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            value_valid,
	output logic [7:0]                      value_byte,
	output logic                            finished,
	output logic                            outcome,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_data
);

	jkse_pkg::cfg_t cfg;
	jkse_pkg::res_t res;
	jkse_pkg::res_t res_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       valid_s2;
	logic       advance;
	logic       in_take;

	assign cfg_ready = 1'b1;

	jkse_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the byte in the input register moves on when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	jkse_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (byte_s1),
		.is_final  (final_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= text_byte;
			final_s1 <= is_final;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign value_valid = res_s2.value_valid;
	assign value_byte  = res_s2.value_byte;
	assign finished    = res_s2.finished;
	assign outcome     = res_s2.outcome;

endmodule
